/* src/sfb_pkg.sv */
// ----------------------------------------------------------------------------
// sfb_pkg: shared types and constants of the sensor frame builder
// Holds the measurement set type, the frame layout constants and the
// byte-wide CRC-16/MODBUS update used by the word generator.
// ----------------------------------------------------------------------------
package sfb_pkg;

	typedef struct packed {
		logic [7:0]  error_code;
		logic [31:0] gyro_x;
		logic [31:0] gyro_y;
		logic [31:0] gyro_z;
		logic [31:0] accel_x;
		logic [31:0] accel_y;
		logic [31:0] accel_z;
	} sample_t;

	localparam logic [7:0]  HDR_A     = 8'hFA;
	localparam logic [7:0]  HDR_B     = 8'hFB;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam int          GYRO_AT   = 8;
	localparam int          ACCEL_AT  = 24;
	// bytes 0 .. DATA_BYTES-1 carry header, error code and samples
	localparam int          DATA_BYTES = 36;

	localparam int          FIFO_DEPTH = 2;
	localparam int          FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// one byte through the reflected crc, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* src/sfb_item_fifo.sv */
// ----------------------------------------------------------------------------
// sfb_item_fifo: front queue of measurement sets
// Takes requests from the input side and holds them until the word
// generator has sent the whole frame of the oldest one.
// ----------------------------------------------------------------------------
module sfb_item_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  sfb_pkg::sample_t item,
	output logic            head_valid,
	output sfb_pkg::sample_t head,
	input  logic            take
);
	import sfb_pkg::*;

	sample_t                  slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [FIFO_PTR_W:0]      count_q;
	logic                     do_push;
	logic                     do_take;

	assign full       = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_take    = take && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_take) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_take) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

endmodule

/* src/sfb_frame_gen.sv */
// ----------------------------------------------------------------------------
// sfb_frame_gen: frame word generator with running crc
// Walks the queue head's frame one word per cycle while the output is free or
// popped, folds four bytes a cycle into the crc and drops it in its two bytes.
// ----------------------------------------------------------------------------
module sfb_frame_gen #(
	parameter int FRAME_BYTES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  sfb_pkg::sample_t head,
	output logic             take,
	output logic             out_valid,
	output logic [31:0]      out_word,
	output logic             out_last,
	input  logic             out_pop
);
	import sfb_pkg::*;

	localparam int WORDS = (FRAME_BYTES + 3) / 4;
	localparam int WIDX  = $clog2(WORDS);
	localparam int PW    = WIDX + 2;
	localparam logic [PW-1:0]   TRAIL_POS  = PW'(FRAME_BYTES - 4);
	localparam logic [PW-1:0]   TRAIL2_POS = PW'(FRAME_BYTES - 3);
	localparam logic [PW-1:0]   CRC_POS    = PW'(FRAME_BYTES - 2);
	localparam logic [PW-1:0]   CRC2_POS   = PW'(FRAME_BYTES - 1);
	localparam logic [PW-1:0]   DATA_END   = PW'(DATA_BYTES);
	localparam logic [WIDX-1:0] LAST_IDX   = WIDX'(WORDS - 1);

	logic [WIDX-1:0] word_q;
	logic [15:0]     crc_q;
	logic            out_valid_q;
	logic [31:0]     out_word_q;
	logic            out_last_q;

	logic [7:0]      data_b [DATA_BYTES];
	logic [15:0]     crc_v;
	logic [31:0]     word_v;
	logic            advance;
	logic            is_last;

	always_comb begin
		for (int k = 0; k < DATA_BYTES; k++) begin
			data_b[k] = 8'h00;
		end
		data_b[0] = HDR_A;
		data_b[1] = HDR_B;
		data_b[2] = head.error_code;
		for (int k = 0; k < 4; k++) begin
			data_b[6'(GYRO_AT + k)]       = head.gyro_x[8*k +: 8];
			data_b[6'(GYRO_AT + 4 + k)]   = head.gyro_y[8*k +: 8];
			data_b[6'(GYRO_AT + 8 + k)]   = head.gyro_z[8*k +: 8];
			data_b[6'(ACCEL_AT + k)]      = head.accel_x[8*k +: 8];
			data_b[6'(ACCEL_AT + 4 + k)]  = head.accel_y[8*k +: 8];
			data_b[6'(ACCEL_AT + 8 + k)]  = head.accel_z[8*k +: 8];
		end
	end

	// crc bytes come after every covered byte, so crc_v is final there
	always_comb begin
		logic [PW-1:0] pos;
		logic [7:0]    bv;
		crc_v  = crc_q;
		word_v = '0;
		for (int j = 0; j < 4; j++) begin
			pos = {word_q, 2'(j)};
			if (pos < CRC_POS) begin
				if (pos < DATA_END) begin
					bv = data_b[pos[5:0]];
				end else if (pos == TRAIL_POS) begin
					bv = HDR_A;
				end else if (pos == TRAIL2_POS) begin
					bv = HDR_B;
				end else begin
					bv = 8'h00;
				end
				crc_v = crc_byte(crc_v, bv);
			end else if (pos == CRC_POS) begin
				bv = crc_v[7:0];
			end else if (pos == CRC2_POS) begin
				bv = crc_v[15:8];
			end else begin
				bv = 8'h00;
			end
			word_v[8*j +: 8] = bv;
		end
	end

	assign is_last = (word_q == LAST_IDX);
	assign advance = head_valid && (!out_valid_q || out_pop);
	assign take    = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					word_q <= '0;
					crc_q  <= CRC_INIT;
				end else begin
					word_q <= word_q + 1'b1;
					crc_q  <= crc_v;
				end
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= word_v;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_last  = out_last_q;

endmodule

/* src/sensor_frame_builder_crc16.sv */
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc16: sensor frame builder with CRC-16/MODBUS
// Turns one measurement set into a framed packet of little-endian words.
// ----------------------------------------------------------------------------
// Input side is a queue: a request (error code plus six sample words) is
// taken when push is high and full is low. A two-entry queue holds sets
// until their frames are sent, so a new set is taken while one is in work.
// Result side is a queue too: while empty is low the oldest frame word and
// last_word are on the ports, and pop takes it.
// Each set gives (FRAME_BYTES+3)/4 words, 32 at the default size; last_word
// marks the final one. The first word of a set is registered into the
// output register from the queue head once that register is free.
// Words leave one per cycle while pop stays high; the word counter and
// one four-byte crc step per cycle set that rate. A single output
// register parts the word generator from the receiver: when pop is low
// while a word waits, the generator and the queue behind it hold, and
// push sees full once two sets wait.
// Reset clears the queue, the word counter and the crc; a frame cut off by
// reset is dropped and not resumed.
// ----------------------------------------------------------------------------
module sensor_frame_builder_crc16 #(
	parameter int FRAME_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  error_code,
	input  logic [31:0] gyro_x,
	input  logic [31:0] gyro_y,
	input  logic [31:0] gyro_z,
	input  logic [31:0] accel_x,
	input  logic [31:0] accel_y,
	input  logic [31:0] accel_z,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] frame_word,
	output logic        last_word
);
	import sfb_pkg::*;

	sample_t item;
	sample_t head;
	logic    head_valid;
	logic    take;
	logic    out_valid;

	assign item = '{error_code: error_code, gyro_x: gyro_x, gyro_y: gyro_y, gyro_z: gyro_z,
		accel_x: accel_x, accel_y: accel_y, accel_z: accel_z};

	sfb_item_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.take       (take)
	);

	sfb_frame_gen #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.take       (take),
		.out_valid  (out_valid),
		.out_word   (frame_word),
		.out_last   (last_word),
		.out_pop    (pop)
	);

	assign empty = !out_valid;

	a_take_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> head_valid)
		else $error("frame finished without a queued set");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> head_valid)
		else $error("accepted set not visible at queue head");

	a_take_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !empty && last_word)
		else $error("set released without last word on output");

endmodule
